FILE: design/epoch_seconds_to_datetime_macros.svh
// Assertion helpers shared by the epoch_seconds_to_datetime design.
// Both expect i_clk and i_rst_n in scope.
`ifndef EPOCH_SECONDS_TO_DATETIME_MACROS_SVH
`define EPOCH_SECONDS_TO_DATETIME_MACROS_SVH

// same-cycle implication
`define ESD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("esd check failed");

// next-cycle implication
`define ESD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("esd check failed");

`endif

FILE: design/esd_pkg.sv
package esd_pkg;

    localparam int DAYS_W = 16;

    typedef logic [DAYS_W-1:0] t_days;

    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
    localparam logic [5:0]  DAY_HOURS     = 6'd24;
    localparam logic [2:0]  WEEK_LEN      = 3'd7;
    localparam logic [7:0]  LEAP_PERIOD   = 8'd4;
    localparam t_days       QUAD_DAYS     = 16'd1461;
    localparam t_days       LEAP_YEAR_LEN = 16'd366;
    localparam t_days       YEAR_LEN      = 16'd365;
    localparam logic [4:0]  MLEN_LONG     = 5'd31;
    localparam logic [4:0]  MLEN_SHORT    = 5'd30;
    localparam logic [4:0]  FEB_LEAP      = 5'd29;
    localparam logic [4:0]  FEB_NORM      = 5'd28;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;

    // x / d == (x * RECIP) >> SHIFT for every 32-bit x
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam int          SHIFT_60 = 37;
    localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
    localparam int          SHIFT_24 = 36;
    // exact below 104857, which covers every day count
    localparam logic [31:0] RECIP_7  = 32'd74899;
    localparam int          SHIFT_7  = 19;

    // which divisor the multiplier is working with
    localparam logic [1:0]  DIV_SEC  = 2'd0;
    localparam logic [1:0]  DIV_MIN  = 2'd1;
    localparam logic [1:0]  DIV_HOUR = 2'd2;
    localparam logic [1:0]  DIV_WEEK = 2'd3;

    typedef struct packed {
        logic [7:0] year_offset;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [2:0] weekday;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
    } t_datetime;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    typedef struct packed {
        t_days diff;
        logic  gt;
    } t_sub_res;

    // month index 0 is January
    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m) inside
            4'd1:                   len = leap ? FEB_LEAP : FEB_NORM;
            4'd3, 4'd5, 4'd8, 4'd10: len = MLEN_SHORT;
            default:                len = MLEN_LONG;
        endcase
        return len;
    endfunction

    // day count minus one, mod 7, gives the weekday with 0 as Sunday
    function automatic logic [2:0] weekday_of(input logic [2:0] qmod);
        return (qmod == 3'd0) ? (WEEK_LEN - 3'd1) : (qmod - 3'd1);
    endfunction

    // x - q * d on the low bits; the true remainder is below 64
    function automatic logic [5:0] low_rem(input logic [5:0] x, input logic [5:0] q,
                                           input logic [5:0] d);
        logic [11:0] p;
        p = 12'(q) * 12'(d);
        return x - p[5:0];
    endfunction

endpackage

FILE: design/esd_in_if.sv
interface esd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_seconds;

    modport source (output valid, output elapsed_seconds, input ready);
    modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

FILE: design/esd_out_if.sv
interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] year_offset;
    logic [3:0] month_number;
    logic [4:0] day_of_month;
    logic [2:0] weekday;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;

    modport source (output valid, output year_offset, output month_number,
                    output day_of_month, output weekday, output hour_of_day,
                    output minute_of_hour, output second_of_minute, input ready);
    modport sink   (input valid, input year_offset, input month_number,
                    input day_of_month, input weekday, input hour_of_day,
                    input minute_of_hour, input second_of_minute, output ready);
endinterface

FILE: design/epoch_seconds_to_datetime.sv
// epoch_seconds_to_datetime
//
// Input channel i_in_ch carries a 32-bit count of seconds since 2000-01-01
// 00:00:00; output channel o_out_ch carries one calendar word per input word
// (year offset, month, day, weekday, hour, minute, second). Both channels use
// valid/ready; a word moves on a clock edge with both high.
//
// o_out_ch.valid rises after the reciprocal divisions by 60, 60, 24 and 7
// (multiply, then remainder), up to 34 four-year steps, 3 single-year steps
// and 11 month steps on the shared subtractor, an exit state per loop and a
// handoff state that waits for the output register. i_in_ch.ready is high
// only while the core is idle: a new word waits until the last is handed off.
//
// A finished word sits in the output register; the core then takes the next
// input word while the receiver stalls, and holds its own result until the
// output register frees up.
// Reset (i_rst_n low at a clock edge) empties the output register and
// returns the core to idle.
`include "epoch_seconds_to_datetime_macros.svh"

module epoch_seconds_to_datetime (
    input  logic         i_clk,
    input  logic         i_rst_n,
    esd_in_if.sink       i_in_ch,
    esd_out_if.source    o_out_ch
);

    esd_pkg::t_core_stat w_stat;
    esd_pkg::t_datetime  w_dt;
    esd_pkg::t_datetime  r_out;
    logic                r_out_valid;
    logic                w_start;
    logic                w_load;
    logic                w_date_ok;
    logic                w_time_ok;

    assign i_in_ch.ready = w_stat.idle;
    assign w_start       = i_in_ch.valid && w_stat.idle;
    assign w_load        = w_stat.done && (!r_out_valid || o_out_ch.ready);

    esd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_secs  (i_in_ch.elapsed_seconds),
        .i_take  (w_load),
        .o_stat  (w_stat),
        .o_dt    (w_dt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_dt;
        end
    end

    assign o_out_ch.valid            = r_out_valid;
    assign o_out_ch.year_offset      = r_out.year_offset;
    assign o_out_ch.month_number     = r_out.month_number;
    assign o_out_ch.day_of_month     = r_out.day_of_month;
    assign o_out_ch.weekday          = r_out.weekday;
    assign o_out_ch.hour_of_day      = r_out.hour_of_day;
    assign o_out_ch.minute_of_hour   = r_out.minute_of_hour;
    assign o_out_ch.second_of_minute = r_out.second_of_minute;

    assign w_date_ok = (o_out_ch.month_number != 4'd0) && (o_out_ch.month_number <= 4'd12)
                       && (o_out_ch.day_of_month != 5'd0);
    assign w_time_ok = (o_out_ch.weekday != 3'd7) && (o_out_ch.hour_of_day <= 5'd23)
                       && (o_out_ch.minute_of_hour <= 6'd59)
                       && (o_out_ch.second_of_minute <= 6'd59);

    `ESD_ASSERT_NEXT(a_busy_after_accept, w_start, !i_in_ch.ready)
    `ESD_ASSERT_NEXT(a_load_gives_valid, w_load, o_out_ch.valid)
    `ESD_ASSERT_NOW(a_date_range, o_out_ch.valid, w_date_ok)
    `ESD_ASSERT_NOW(a_time_range, o_out_ch.valid, w_time_ok)

endmodule

FILE: design/esd_sub.sv
module esd_sub (
    input  esd_pkg::t_days    i_a,
    input  esd_pkg::t_days    i_b,
    output esd_pkg::t_sub_res o_res
);

    logic [esd_pkg::DAYS_W:0] w_diff;

    assign w_diff       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff   = w_diff[esd_pkg::DAYS_W-1:0];
    assign o_res.gt     = !w_diff[esd_pkg::DAYS_W] && (w_diff[esd_pkg::DAYS_W-1:0] != '0);

endmodule

FILE: design/esd_core.sv
module esd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_secs,
    input  logic                i_take,
    output esd_pkg::t_core_stat o_stat,
    output esd_pkg::t_datetime  o_dt
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_REM   = 7'b0000100,
        S_QUAD  = 7'b0001000,
        S_YEAR  = 7'b0010000,
        S_MONTH = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_idx, n_idx;
    logic [31:0]       r_work, n_work;
    logic [31:0]       r_quot, n_quot;
    esd_pkg::t_days    r_days, n_days;
    logic [7:0]        r_year, n_year;
    logic [3:0]        r_month, n_month;
    logic [5:0]        r_sec, n_sec;
    logic [5:0]        r_min, n_min;
    logic [4:0]        r_hour, n_hour;
    logic [2:0]        r_wday, n_wday;

    logic [31:0]       w_recip;
    logic [5:0]        w_divisor;
    logic [63:0]       w_prod;
    logic [31:0]       w_quot;
    logic [5:0]        w_rem;
    esd_pkg::t_days    w_sub_a, w_sub_b;
    esd_pkg::t_sub_res w_sub;
    logic              w_leap;

    assign w_leap = (r_year[1:0] == 2'b00);

    always_comb begin
        unique case (r_idx)
            esd_pkg::DIV_SEC: begin
                w_recip   = esd_pkg::RECIP_60;
                w_divisor = esd_pkg::SECS_PER_MIN;
            end
            esd_pkg::DIV_MIN: begin
                w_recip   = esd_pkg::RECIP_60;
                w_divisor = esd_pkg::MINS_PER_HOUR;
            end
            esd_pkg::DIV_HOUR: begin
                w_recip   = esd_pkg::RECIP_24;
                w_divisor = esd_pkg::DAY_HOURS;
            end
            esd_pkg::DIV_WEEK: begin
                w_recip   = esd_pkg::RECIP_7;
                w_divisor = 6'(esd_pkg::WEEK_LEN);
            end
        endcase
    end

    assign w_prod = 64'(r_work) * 64'(w_recip);

    always_comb begin
        unique case (r_idx) inside
            esd_pkg::DIV_SEC, esd_pkg::DIV_MIN: w_quot = 32'(w_prod[63:esd_pkg::SHIFT_60]);
            esd_pkg::DIV_HOUR:                  w_quot = 32'(w_prod[63:esd_pkg::SHIFT_24]);
            esd_pkg::DIV_WEEK:                  w_quot = 32'(w_prod[63:esd_pkg::SHIFT_7]);
        endcase
    end

    assign w_rem = esd_pkg::low_rem(r_work[5:0], r_quot[5:0], w_divisor);

    esd_sub u_sub (
        .i_a   (w_sub_a),
        .i_b   (w_sub_b),
        .o_res (w_sub)
    );

    always_comb begin
        w_sub_a = '0;
        w_sub_b = '0;
        unique case (r_state)
            S_QUAD: begin
                w_sub_a = r_days;
                w_sub_b = esd_pkg::QUAD_DAYS;
            end
            S_YEAR: begin
                w_sub_a = r_days;
                w_sub_b = w_leap ? esd_pkg::LEAP_YEAR_LEN : esd_pkg::YEAR_LEN;
            end
            S_MONTH: begin
                w_sub_a = r_days;
                w_sub_b = esd_pkg::t_days'(esd_pkg::month_days(w_leap, r_month));
            end
            default: begin
                w_sub_a = '0;
                w_sub_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_work  = r_work;
        n_quot  = r_quot;
        n_days  = r_days;
        n_year  = r_year;
        n_month = r_month;
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_wday  = r_wday;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL;
                    n_work  = i_secs;
                    n_idx   = esd_pkg::DIV_SEC;
                end
            end
            S_MUL: begin
                n_quot  = w_quot;
                n_state = S_REM;
            end
            S_REM: begin
                n_work  = r_quot;
                n_state = S_MUL;
                unique case (r_idx)
                    esd_pkg::DIV_SEC: begin
                        n_sec = w_rem;
                        n_idx = esd_pkg::DIV_MIN;
                    end
                    esd_pkg::DIV_MIN: begin
                        n_min = w_rem;
                        n_idx = esd_pkg::DIV_HOUR;
                    end
                    esd_pkg::DIV_HOUR: begin
                        // quotient is the day count minus one
                        n_hour = w_rem[4:0];
                        n_days = r_quot[esd_pkg::DAYS_W-1:0] + 1'b1;
                        n_idx  = esd_pkg::DIV_WEEK;
                    end
                    esd_pkg::DIV_WEEK: begin
                        n_wday  = esd_pkg::weekday_of(w_rem[2:0]);
                        n_year  = '0;
                        n_state = S_QUAD;
                    end
                endcase
            end
            S_QUAD: begin
                if (w_sub.gt) begin
                    n_days = w_sub.diff;
                    n_year = r_year + esd_pkg::LEAP_PERIOD;
                end else begin
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                if (w_sub.gt) begin
                    n_days = w_sub.diff;
                    n_year = r_year + 1'b1;
                end else begin
                    n_month = '0;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (w_sub.gt && (r_month != esd_pkg::LAST_MONTH)) begin
                    n_days  = w_sub.diff;
                    n_month = r_month + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= esd_pkg::DIV_SEC;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_quot  <= n_quot;
        r_days  <= n_days;
        r_year  <= n_year;
        r_month <= n_month;
        r_sec   <= n_sec;
        r_min   <= n_min;
        r_hour  <= n_hour;
        r_wday  <= n_wday;
    end

    assign o_stat.idle         = (r_state == S_IDLE);
    assign o_stat.done         = (r_state == S_DONE);
    assign o_dt.year_offset      = r_year;
    assign o_dt.month_number     = r_month + 1'b1;
    assign o_dt.day_of_month     = r_days[4:0];
    assign o_dt.weekday          = r_wday;
    assign o_dt.hour_of_day      = r_hour;
    assign o_dt.minute_of_hour   = r_min;
    assign o_dt.second_of_minute = r_sec;

endmodule

FILE: dv/esd_tb_pkg.sv
`timescale 1ns / 100ps

package esd_tb_pkg;

    import esd_pkg::*;

    class datetime_scoreboard;
        t_datetime expected_dates[$];
        int        mismatches = 0;

        static function t_datetime to_calendar(logic [31:0] secs);
            t_datetime   d;
            int unsigned total_min;
            int unsigned total_hr;
            int unsigned day_cnt;
            int unsigned wd;
            int unsigned yr;
            int unsigned mo;
            int unsigned mlen;
            d.second_of_minute = 6'(secs % 60);
            total_min          = secs / 60;
            d.minute_of_hour   = 6'(total_min % 60);
            total_hr           = total_min / 60;
            d.hour_of_day      = 5'(total_hr % 24);
            day_cnt            = 1 + total_hr / 24;
            // day 1 (2000-01-01) was a Saturday
            wd = (4 + day_cnt) % 7 + 1;
            if (wd == 7) begin
                wd = 0;
            end
            yr = 0;
            while (day_cnt > ((yr % 4 == 0) ? 366 : 365)) begin
                day_cnt -= (yr % 4 == 0) ? 366 : 365;
                yr++;
            end
            mo = 0;
            while (mo < 11) begin
                if (mo == 1) begin
                    mlen = (yr % 4 == 0) ? 29 : 28;
                end else if (mo == 3 || mo == 5 || mo == 8 || mo == 10) begin
                    mlen = 30;
                end else begin
                    mlen = 31;
                end
                if (day_cnt <= mlen) begin
                    break;
                end
                day_cnt -= mlen;
                mo++;
            end
            d.year_offset  = 8'(yr);
            d.month_number = 4'(mo + 1);
            d.day_of_month = 5'(day_cnt);
            d.weekday      = 3'(wd);
            return d;
        endfunction

        function void note_seconds(logic [31:0] secs);
            expected_dates.push_back(to_calendar(secs));
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_date(t_datetime got);
            t_datetime want;
            if (expected_dates.size() == 0) begin
                $error("result word with no input pending");
                mismatches++;
                return;
            end
            want = expected_dates.pop_front();
            compare_field("year_offset", want.year_offset, got.year_offset);
            compare_field("month_number", want.month_number, got.month_number);
            compare_field("day_of_month", want.day_of_month, got.day_of_month);
            compare_field("weekday", want.weekday, got.weekday);
            compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
            compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
            compare_field("second_of_minute", want.second_of_minute,
                          got.second_of_minute);
        endfunction
    endclass

endpackage

FILE: dv/epoch_seconds_to_datetime_test.sv
`timescale 1ns / 100ps

module epoch_seconds_to_datetime_test;

    import esd_pkg::*;
    import esd_tb_pkg::*;

    localparam int RANDOM_WORDS = 1900;
    localparam int HOLD_AT      = 600;
    localparam int DRAIN_AT     = 1200;
    localparam int LONG_HOLD    = 3000;
    localparam int QUIET_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 300;
    localparam longint SECS_PER_DAY = 86400;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   hold_req = 1'b0;
    int   quiet_cycles = 0;

    datetime_scoreboard sb;

    esd_in_if  in_ch ();
    esd_out_if out_ch ();

    epoch_seconds_to_datetime u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_seconds(in_ch.elapsed_seconds);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_date({out_ch.year_offset, out_ch.month_number, out_ch.day_of_month,
                           out_ch.weekday, out_ch.hour_of_day, out_ch.minute_of_hour,
                           out_ch.second_of_minute});
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("epoch_seconds_to_datetime regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stall patterns that change over the run, one long hold
    initial begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic [31:0] secs);
        in_ch.valid <= 1'b1;
        in_ch.elapsed_seconds <= secs;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // mix of raw words, day edges, month/year edges and the top of the range
    function automatic logic [31:0] random_seconds();
        int     kind;
        int     yr;
        int     mo;
        longint days;
        longint t;
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
            return $urandom;
        end else if (kind <= 5) begin
            t = longint'($urandom_range(0, 49709)) * SECS_PER_DAY;
            t += $urandom_range(0, 1) ? $urandom_range(0, 3) : 86399 - $urandom_range(0, 3);
            return 32'(t);
        end else if (kind <= 8) begin
            yr = $urandom_range(0, 135);
            mo = $urandom_range(0, 11);
            days = yr * 365 + (yr + 3) / 4;
            for (int m = 0; m < mo; m++) begin
                if (m == 1) begin
                    days += (yr % 4 == 0) ? 29 : 28;
                end else if (m == 3 || m == 5 || m == 8 || m == 10) begin
                    days += 30;
                end else begin
                    days += 31;
                end
            end
            t = days * SECS_PER_DAY;
            if ($urandom_range(0, 1) || t == 0) begin
                t += $urandom_range(0, 59);
            end else begin
                t -= 1 + $urandom_range(0, 59);
            end
            return 32'(t);
        end
        return 32'hFFFF_FFFF - $urandom_range(0, 100000);
    endfunction

    initial begin
        logic [31:0] directed_words[$] = '{
            32'd0, 32'd60, 32'd3600, 32'd86399, 32'd86400,
            32'd172800, 32'd259200, 32'd345600, 32'd432000, 32'd518400,
            32'd5097599, 32'd5097600, 32'd5183999, 32'd5184000,
            32'd31622399, 32'd31622400, 32'd36719999, 32'd36720000,
            32'd3160857600, 32'd3160944000, 32'd4291833599,
            32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000
        };
        int burst_left;
        sb = new();
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.elapsed_seconds <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[k]) begin
            send_word(directed_words[k]);
        end
        wait_drained();

        burst_left = 0;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == HOLD_AT) begin
                hold_req = 1'b1;
            end
            if (i == DRAIN_AT) begin
                wait_drained();
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) begin
                    idle_cycles($urandom_range(0, 1) ? $urandom_range(1, 8)
                                                     : $urandom_range(9, 250));
                end
            end
            send_word(random_seconds());
            burst_left--;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("epoch_seconds_to_datetime regression: pass");
        end else begin
            $display("epoch_seconds_to_datetime regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/esd_pkg.sv
design/esd_in_if.sv
design/esd_out_if.sv
design/esd_sub.sv
design/esd_core.sv
design/epoch_seconds_to_datetime.sv
dv/esd_tb_pkg.sv
dv/epoch_seconds_to_datetime_test.sv
